FILE: hdl/cda_pkg.sv
package cda_pkg;

	// operation codes
	localparam logic [2:0] MODE_SET    = 3'd0;
	localparam logic [2:0] MODE_DAYS   = 3'd1;
	localparam logic [2:0] MODE_MONTHS = 3'd2;
	localparam logic [2:0] MODE_YEARS  = 3'd3;
	localparam logic [2:0] MODE_CHECK  = 3'd4;

	// calendar limits
	localparam logic [11:0] YEAR_MIN      = 12'd1500;
	localparam logic [11:0] YEAR_MAX      = 12'd3000;
	localparam logic [11:0] YEAR_TOP      = 12'd4095;
	localparam logic [3:0]  MONTH_FIRST   = 4'd1;
	localparam logic [3:0]  MONTH_LAST    = 4'd12;
	localparam logic [3:0]  MONTH_FEB     = 4'd2;
	localparam logic [4:0]  FEB_LEAP_DAYS = 5'd29;

	// reset date
	localparam logic [4:0]  RST_DAY   = 5'd27;
	localparam logic [3:0]  RST_MONTH = 4'd9;
	localparam logic [11:0] RST_YEAR  = 12'd2006;

	// x / 12 as (x * MONTH_RECIP) >> MONTH_SHIFT, exact for x below 4107
	localparam logic [12:0] MONTH_RECIP = 13'd5462;
	localparam int          MONTH_SHIFT = 16;

	localparam logic [4:0] MONTH_LEN [0:12] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef struct packed {
		logic [2:0]  mode;
		logic [4:0]  day_in;
		logic [3:0]  month_in;
		logic [11:0] year_in;
		logic [11:0] amount;
	} cmd_t;

	typedef struct packed {
		logic [4:0]  day_out;
		logic [3:0]  month_out;
		logic [11:0] year_out;
		logic        leap_year;
		logic        date_valid;
		logic        overflow;
	} res_t;

	// one month step of the shared unit
	typedef struct packed {
		logic [4:0]  len;
		logic        over;
		logic [12:0] rest;
		logic [3:0]  next_month;
		logic [11:0] next_year;
		logic        year_ovf;
	} step_t;

	// gregorian leap rule; divisibility by 25 via the inverse of 25 (41) mod 2^n
	function automatic logic is_leap(input logic [11:0] y);
		logic [9:0] p4;
		logic [7:0] p16;
		logic       div4;
		logic       div100;
		logic       div400;
		p4     = 10'(y[11:2] * 10'd41);
		p16    = 8'(y[11:4] * 8'd41);
		div4   = (y[1:0] == 2'd0);
		div100 = div4 && (p4 <= 10'd40);
		div400 = (y[3:0] == 4'd0) && (p16 <= 8'd10);
		return (div4 && !div100) || div400;
	endfunction

	// month length, zero for a month outside 1..12
	function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		len = 5'd0;
		if (m >= MONTH_FIRST && m <= MONTH_LAST) begin
			if (m == MONTH_FEB && leap)
				len = FEB_LEAP_DAYS;
			else
				len = MONTH_LEN[m];
		end
		return len;
	endfunction

endpackage

FILE: hdl/cda_month_step.sv
module cda_month_step
	import cda_pkg::*;
(
	input  logic [12:0] total,
	input  logic [3:0]  month,
	input  logic [11:0] year,
	output step_t       step
);

	logic [4:0] len;
	logic       wrap;

	// month length and compare against the running day total
	assign len  = days_in(month, is_leap(year));
	assign wrap = (month == MONTH_LAST);

	always_comb begin
		step.len        = len;
		step.over       = total > {8'd0, len};
		step.rest       = total - {8'd0, len};
		step.next_month = wrap ? MONTH_FIRST : month + 4'd1;
		step.next_year  = wrap ? year + 12'd1 : year;
		step.year_ovf   = wrap && (year == YEAR_TOP);
	end

endmodule

FILE: hdl/calendar_date_arithmetic.sv
// Calendar date register: holds one gregorian date (reset value 27 Sep 2006)
// and applies set, add days, add months, add years and check operations.
// Command channel: cmd carries mode, day_in, month_in, year_in and amount; a
// transaction happens on a rising edge with cmd_valid high and cmd_stall low.
// Result channel: res carries the stored date after the operation, its leap
// flag, date_valid and overflow; a transaction happens with res_valid high
// and res_stall low. One result per command.
// One command is in work at a time; cmd_stall is high from acceptance until
// the result is loaded into the output register.
// After acceptance, set, check, add years and unused codes finish in the
// EXEC state; add months passes EXEC, where a multiply takes the quotient
// of the division by 12, then ST_MONR; add days passes EXEC, then ST_DAYS,
// where the month-step unit walks one month per cycle over each boundary.
// The next command may be accepted the cycle after the result is loaded,
// so commands do not overlap in the sequencer.
// A stalled result holds in the output register; the block may accept and
// work on one more command, which then waits to finish until the slot frees.
// Reset clears the sequencer and output valid and loads the reset date.
module calendar_date_arithmetic
	import cda_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DAYS = 2'd2;
	localparam logic [1:0] ST_MONR = 2'd3;

	logic [1:0]  st_q;
	cmd_t        cmd_q;
	logic [4:0]  cur_day_q;
	logic [3:0]  cur_month_q;
	logic [11:0] cur_year_q;
	logic [12:0] tot_q;
	logic [3:0]  wm_q;
	logic [11:0] wy_q;
	logic [8:0]  quo_q;
	logic        res_valid_q;
	res_t        res_q;

	logic        out_free;
	logic        fin;
	logic        done;
	logic [4:0]  nxt_day;
	logic [3:0]  nxt_month;
	logic [11:0] nxt_year;
	logic        nxt_valid;
	logic        nxt_ovf;
	logic        year_ok;
	logic        month_ok;
	logic        day_ok;
	logic [11:0] set_year;
	logic [3:0]  set_month;
	logic [12:0] u_total;
	logic [3:0]  u_month;
	logic [11:0] u_year;
	step_t       stp;
	logic [12:0] mon_total;
	logic [25:0] mon_prod;
	logic [12:0] quo_x12;
	logic [12:0] mon_rem;
	logic [12:0] mon_year;
	logic [12:0] add_year;

	assign cmd_stall = (st_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign out_free  = !res_valid_q || !res_stall;
	assign done      = fin && out_free;

	// field checks for set and check
	assign year_ok   = (cmd_q.year_in inside {[YEAR_MIN:YEAR_MAX]});
	assign month_ok  = (cmd_q.month_in inside {[MONTH_FIRST:MONTH_LAST]});
	assign set_year  = year_ok ? cmd_q.year_in : cur_year_q;
	assign set_month = month_ok ? cmd_q.month_in : cur_month_q;

	// shared unit input select: day walk or day-fits-month test
	always_comb begin
		if (st_q == ST_DAYS) begin
			u_total = tot_q;
			u_month = wm_q;
			u_year  = wy_q;
		end else begin
			u_total = {8'd0, cmd_q.day_in};
			u_month = (cmd_q.mode == MODE_CHECK) ? cmd_q.month_in : set_month;
			u_year  = (cmd_q.mode == MODE_CHECK) ? cmd_q.year_in : set_year;
		end
	end

	cda_month_step u_step (
		.total (u_total),
		.month (u_month),
		.year  (u_year),
		.step  (stp)
	);

	assign day_ok = (cmd_q.day_in != 5'd0) && !stp.over;

	// add months: quotient by reciprocal multiply, remainder in the next cycle
	assign mon_total = {9'd0, cur_month_q - 4'd1} + {1'b0, cmd_q.amount};
	assign mon_prod  = 26'(mon_total) * 26'(MONTH_RECIP);
	assign quo_x12   = {1'b0, quo_q, 3'd0} + {2'b0, quo_q, 2'd0};
	assign mon_rem   = tot_q - quo_x12;
	assign mon_year  = {1'b0, cur_year_q} + {4'd0, quo_q};

	// add years
	assign add_year = {1'b0, cur_year_q} + {1'b0, cmd_q.amount};

	// result of the finishing cycle
	always_comb begin
		fin       = 1'b0;
		nxt_day   = cur_day_q;
		nxt_month = cur_month_q;
		nxt_year  = cur_year_q;
		nxt_valid = 1'b0;
		nxt_ovf   = 1'b0;
		case (st_q)
			ST_EXEC: begin
				case (cmd_q.mode)
					MODE_SET: begin
						fin       = 1'b1;
						nxt_year  = set_year;
						nxt_month = set_month;
						nxt_day   = day_ok ? cmd_q.day_in : cur_day_q;
						nxt_valid = year_ok && month_ok && day_ok;
					end
					MODE_DAYS, MODE_MONTHS: begin
						fin = 1'b0;
					end
					MODE_YEARS: begin
						fin = 1'b1;
						if (add_year[12])
							nxt_ovf = 1'b1;
						else
							nxt_year = add_year[11:0];
					end
					MODE_CHECK: begin
						fin       = 1'b1;
						nxt_valid = year_ok && month_ok && day_ok;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			ST_DAYS: begin
				if (stp.over) begin
					if (stp.year_ovf) begin
						fin     = 1'b1;
						nxt_ovf = 1'b1;
					end
				end else begin
					fin       = 1'b1;
					nxt_day   = tot_q[4:0];
					nxt_month = wm_q;
					nxt_year  = wy_q;
				end
			end
			ST_MONR: begin
				fin = 1'b1;
				if (mon_year[12]) begin
					nxt_ovf = 1'b1;
				end else begin
					nxt_month = mon_rem[3:0] + 4'd1;
					nxt_year  = mon_year[11:0];
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (cmd_valid)
						st_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (cmd_q.mode == MODE_DAYS)
						st_q <= ST_DAYS;
					else if (cmd_q.mode == MODE_MONTHS)
						st_q <= ST_MONR;
					else if (done)
						st_q <= ST_IDLE;
				end
				ST_DAYS, ST_MONR: begin
					if (done)
						st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command capture and working registers
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && cmd_valid)
			cmd_q <= cmd;
		if (st_q == ST_EXEC && cmd_q.mode == MODE_DAYS) begin
			tot_q <= {8'd0, cur_day_q} + {1'b0, cmd_q.amount};
			wm_q  <= cur_month_q;
			wy_q  <= cur_year_q;
		end else if (st_q == ST_EXEC && cmd_q.mode == MODE_MONTHS) begin
			tot_q <= mon_total;
			quo_q <= mon_prod[MONTH_SHIFT +: 9];
		end else if (st_q == ST_DAYS && stp.over && !stp.year_ovf) begin
			tot_q <= stp.rest;
			wm_q  <= stp.next_month;
			wy_q  <= stp.next_year;
		end
	end

	// stored date
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_day_q   <= RST_DAY;
			cur_month_q <= RST_MONTH;
			cur_year_q  <= RST_YEAR;
		end else if (done) begin
			cur_day_q   <= nxt_day;
			cur_month_q <= nxt_month;
			cur_year_q  <= nxt_year;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q.day_out    <= nxt_day;
			res_q.month_out  <= nxt_month;
			res_q.year_out   <= nxt_year;
			res_q.leap_year  <= is_leap(nxt_year);
			res_q.date_valid <= nxt_valid;
			res_q.overflow   <= nxt_ovf;
		end
	end

endmodule

FILE: verif/calendar_date_arithmetic_test.sv
module calendar_date_arithmetic_test
	import cda_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// the three codes with no operation behind them
	localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
	localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

	localparam int RANDOM_ITEMS = 420;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int REPORT_LIMIT = 10;

	// shadow of the stored date and the results it leads to
	class calendar_shadow;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
		res_t        dates_due[$];
		int          mode_count[8];
		int          compared;
		int          mismatches;
		int          unexpected;
		int          reported;

		function new();
			day = RST_DAY;
			month = RST_MONTH;
			year = RST_YEAR;
			foreach (mode_count[i])
				mode_count[i] = 0;
			compared = 0;
			mismatches = 0;
			unexpected = 0;
			reported = 0;
		endfunction

		function bit leap_of(int y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		function int month_days(int m, int y);
			if (m < MONTH_FIRST || m > MONTH_LAST)
				return 0;
			if (m == MONTH_FEB && leap_of(y))
				return FEB_LEAP_DAYS;
			return MONTH_LEN[m];
		endfunction

		function int pending();
			return dates_due.size();
		endfunction

		// apply one accepted command to the shadow date
		function void take_command(cmd_t c);
			res_t r;
			int   total;
			int   nm;
			int   ny;
			int   len;
			bit   ok;
			bit   ovf;
			ok = 1'b0;
			ovf = 1'b0;
			mode_count[c.mode]++;
			case (c.mode)
				MODE_SET: begin
					ok = 1'b1;
					if (c.year_in >= YEAR_MIN && c.year_in <= YEAR_MAX)
						year = c.year_in;
					else
						ok = 1'b0;
					if (c.month_in >= MONTH_FIRST && c.month_in <= MONTH_LAST)
						month = c.month_in;
					else
						ok = 1'b0;
					if (c.day_in >= 1 && c.day_in <= month_days(month, year))
						day = c.day_in;
					else
						ok = 1'b0;
				end
				MODE_DAYS: begin
					total = int'(day) + int'(c.amount);
					nm = month;
					ny = year;
					len = month_days(nm, ny);
					// walk month by month, carrying into the year
					while (len != 0 && total > len) begin
						total -= len;
						nm++;
						if (nm > MONTH_LAST) begin
							nm = MONTH_FIRST;
							ny++;
							if (ny > YEAR_TOP) begin
								ovf = 1'b1;
								break;
							end
						end
						len = month_days(nm, ny);
					end
					if (!ovf) begin
						day = 5'(total);
						month = 4'(nm);
						year = 12'(ny);
					end
				end
				MODE_MONTHS: begin
					total = ((month >= MONTH_FIRST) ? int'(month) - 1 : 0) + int'(c.amount);
					ny = int'(year) + total / 12;
					if (ny > YEAR_TOP) begin
						ovf = 1'b1;
					end else begin
						month = 4'(total % 12 + 1);
						year = 12'(ny);
					end
				end
				MODE_YEARS: begin
					ny = int'(year) + int'(c.amount);
					if (ny > YEAR_TOP)
						ovf = 1'b1;
					else
						year = 12'(ny);
				end
				MODE_CHECK: begin
					ok = (c.year_in >= YEAR_MIN && c.year_in <= YEAR_MAX &&
						c.month_in >= MONTH_FIRST && c.month_in <= MONTH_LAST &&
						c.day_in >= 1 && c.day_in <= month_days(c.month_in, c.year_in));
				end
				default: begin
				end
			endcase
			r.day_out = day;
			r.month_out = month;
			r.year_out = year;
			r.leap_year = leap_of(year);
			r.date_valid = ok;
			r.overflow = ovf;
			dates_due.push_back(r);
		endfunction

		// compare one accepted result with the oldest expected date
		function void compare_result(res_t got);
			res_t want;
			if (dates_due.size() == 0) begin
				unexpected++;
				if (reported < REPORT_LIMIT) begin
					reported++;
					$display("unexpected result: %0d/%0d/%0d leap %0b valid %0b ovf %0b",
						got.day_out, got.month_out, got.year_out, got.leap_year,
						got.date_valid, got.overflow);
				end
				return;
			end
			want = dates_due.pop_front();
			compared++;
			if (got.day_out !== want.day_out || got.month_out !== want.month_out ||
				got.year_out !== want.year_out || got.leap_year !== want.leap_year ||
				got.date_valid !== want.date_valid || got.overflow !== want.overflow) begin
				mismatches++;
				if (reported < REPORT_LIMIT) begin
					reported++;
					$display("mismatch at result %0d: expected %0d/%0d/%0d leap %0b valid %0b ovf %0b",
						compared, want.day_out, want.month_out, want.year_out,
						want.leap_year, want.date_valid, want.overflow);
					$display("    actual %0d/%0d/%0d leap %0b valid %0b ovf %0b",
						got.day_out, got.month_out, got.year_out, got.leap_year,
						got.date_valid, got.overflow);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall;
	res_t res;

	bit             steady;
	int             cycle_count;
	int             leftover;
	calendar_shadow shadow;

	calendar_date_arithmetic dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// result side: random stall, checked at the rising edge
	always @(negedge clk) begin
		res_stall <= !steady && ($urandom_range(0, 99) < 18);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			shadow.compare_result(res);
	end

	function automatic cmd_t make_cmd(logic [2:0] mode, int d, int m, int y, int a);
		cmd_t c;
		c.mode = mode;
		c.day_in = 5'(d);
		c.month_in = 4'(m);
		c.year_in = 12'(y);
		c.amount = 12'(a);
		return c;
	endfunction

	// a date that passes every check
	function automatic cmd_t good_date(logic [2:0] mode);
		int y;
		int m;
		y = $urandom_range(YEAR_MIN, YEAR_MAX);
		m = $urandom_range(MONTH_FIRST, MONTH_LAST);
		return make_cmd(mode, $urandom_range(1, shadow.month_days(m, y)), m, y,
			$urandom_range(0, 4095));
	endfunction

	function automatic cmd_t random_command();
		cmd_t c;
		int   pick;
		int   y;
		int   m;
		pick = $urandom_range(0, 99);
		c = make_cmd(MODE_SET, $urandom_range(0, 31), $urandom_range(0, 15),
			$urandom_range(0, 4095), $urandom_range(0, 4095));
		if (pick < 24) begin
			// set: mostly well-formed dates, some with a bad day, some raw
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				c = good_date(MODE_SET);
			end else if (pick < 75) begin
				y = $urandom_range(YEAR_MIN, YEAR_MAX);
				c.year_in = 12'(y);
				c.month_in = 4'($urandom_range(MONTH_FIRST, MONTH_LAST));
			end
		end else if (pick < 50) begin
			c.mode = MODE_DAYS;
			pick = $urandom_range(0, 99);
			if (pick < 85)
				c.amount = 12'($urandom_range(0, 60));
			else if (pick < 97)
				c.amount = 12'($urandom_range(0, 400));
		end else if (pick < 64) begin
			c.mode = MODE_MONTHS;
			if ($urandom_range(0, 99) < 80)
				c.amount = 12'($urandom_range(0, 30));
		end else if (pick < 74) begin
			c.mode = MODE_YEARS;
			if ($urandom_range(0, 99) < 75)
				c.amount = 12'($urandom_range(0, 20));
		end else if (pick < 93) begin
			// check: dates near month ends and century years, or raw fields
			c.mode = MODE_CHECK;
			if ($urandom_range(0, 99) < 60) begin
				case ($urandom_range(0, 3))
					0: y = 100 * $urandom_range(15, 30);
					1: y = $urandom_range(YEAR_MIN, YEAR_MAX);
					2: y = 4 * $urandom_range(375, 750);
					default: y = ($urandom_range(0, 1) != 0) ? $urandom_range(1490, 1510) :
						$urandom_range(2990, 3010);
				endcase
				m = ($urandom_range(0, 1) != 0) ? MONTH_FEB :
					$urandom_range(MONTH_FIRST, MONTH_LAST);
				c.year_in = 12'(y);
				c.month_in = 4'(m);
				c.day_in = 5'(shadow.month_days(m, y) + $urandom_range(0, 1));
			end
		end else begin
			c.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
		end
		return c;
	endfunction

	// offer one command, with a random gap before it
	task automatic send_cmd(input cmd_t c);
		if (!steady && $urandom_range(0, 99) < 18) begin
			repeat ($urandom_range(1, 3)) begin
				@(negedge clk);
				cmd_valid <= 1'b0;
			end
		end
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		shadow.take_command(c);
	endtask

	task automatic drain_results();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (shadow.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		shadow = new();
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		res_stall = 1'b0;
		steady = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// directed: reset date echo
		send_cmd(make_cmd(MODE_YEARS, 0, 0, 0, 0));
		// set: leap day, a rejected day in a century year, all fields rejected
		send_cmd(make_cmd(MODE_SET, 29, 2, 2000, 0));
		send_cmd(make_cmd(MODE_SET, 29, 2, 1900, 0));
		send_cmd(make_cmd(MODE_DAYS, 0, 0, 0, 0));
		send_cmd(make_cmd(MODE_SET, 0, 0, 0, 0));
		send_cmd(make_cmd(MODE_SET, 31, 15, 4095, 4095));
		send_cmd(make_cmd(MODE_SET, 1, 13, 1499, 0));
		send_cmd(make_cmd(MODE_SET, 31, 12, YEAR_MAX, 0));
		// day carry into the next year, then the longest walk
		send_cmd(make_cmd(MODE_DAYS, 0, 0, 0, 1));
		send_cmd(make_cmd(MODE_DAYS, 0, 0, 0, 4095));
		// a kept day that no longer fits its month
		send_cmd(make_cmd(MODE_SET, 31, 1, 2001, 0));
		send_cmd(make_cmd(MODE_MONTHS, 0, 0, 0, 1));
		send_cmd(make_cmd(MODE_DAYS, 0, 0, 0, 0));
		send_cmd(make_cmd(MODE_MONTHS, 0, 0, 0, 4095));
		// last year, then every add past it
		send_cmd(make_cmd(MODE_SET, 31, 12, YEAR_MAX, 0));
		send_cmd(make_cmd(MODE_YEARS, 0, 0, 0, YEAR_TOP - YEAR_MAX));
		send_cmd(make_cmd(MODE_DAYS, 0, 0, 0, 1));
		send_cmd(make_cmd(MODE_MONTHS, 0, 0, 0, 1));
		send_cmd(make_cmd(MODE_YEARS, 0, 0, 0, 1));
		send_cmd(make_cmd(MODE_YEARS, 0, 0, 0, 4095));
		send_cmd(make_cmd(MODE_DAYS, 0, 0, 0, 0));
		// check: leap rule and bounds
		send_cmd(make_cmd(MODE_CHECK, 29, 2, 2400, 0));
		send_cmd(make_cmd(MODE_CHECK, 29, 2, 2100, 0));
		send_cmd(make_cmd(MODE_CHECK, 31, 4, 2020, 0));
		send_cmd(make_cmd(MODE_CHECK, 0, 0, 0, 0));
		send_cmd(make_cmd(MODE_CHECK, 31, 15, 4095, 4095));
		// unused codes
		for (int k = MODE_SPARE_FIRST; k <= MODE_SPARE_LAST; k++)
			send_cmd(make_cmd(3'(k), 31, 15, 4095, 4095));

		// hold off until everything is back
		drain_results();

		// random part with a quiet window in the middle
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 150 && i < 250);
			send_cmd(random_command());
		end
		steady = 1'b0;

		drain_results();
		repeat (8) @(negedge clk);

		leftover = shadow.pending();
		$display("covered %0d set, %0d add days, %0d add months, %0d add years, %0d check commands",
			shadow.mode_count[MODE_SET], shadow.mode_count[MODE_DAYS],
			shadow.mode_count[MODE_MONTHS], shadow.mode_count[MODE_YEARS],
			shadow.mode_count[MODE_CHECK]);
		$display("%0d results compared, %0d mismatches, %0d unexpected, %0d missing",
			shadow.compared, shadow.mismatches, shadow.unexpected, leftover);
		if (shadow.mismatches == 0 && shadow.unexpected == 0 && leftover == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
